[sv/cic_pkg.sv]
// ----------------------------------------------------------------------------
// cic_pkg
// Shared constants and types for the cloud-in-cell deposit block.
// ----------------------------------------------------------------------------
package cic_pkg;

    localparam int GRID_X = 64;
    localparam int GRID_Y = 64;
    localparam int GRID_Z = 64;

    localparam int XB = $clog2(GRID_X);
    localparam int YB = $clog2(GRID_Y);
    localparam int ZB = $clog2(GRID_Z);
    localparam int AXB = (XB > YB) ? ((XB > ZB) ? XB : ZB) : ((YB > ZB) ? YB : ZB);
    localparam int ADDR_W = XB + YB + ZB;
    localparam int CELLS = GRID_X * GRID_Y * GRID_Z;
    localparam int CELL_W = 48;

    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_INV_X    = 3'd3;
    localparam logic [2:0] REG_INV_Y    = 3'd4;
    localparam logic [2:0] REG_INV_Z    = 3'd5;

    localparam logic FUNC_DEPOSIT = 1'b0;
    localparam logic FUNC_READ    = 1'b1;

    localparam logic [31:0] INV_RESET = 32'h0100_0000;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_AXIS,
        S_W1,
        S_W2,
        S_PROD,
        S_ADD,
        S_RDWAIT
    } state_t;

endpackage

[sv/cic_ram.sv]
// ----------------------------------------------------------------------------
// cic_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module cic_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/cloud_in_cell_deposit.sv]
// ----------------------------------------------------------------------------
// cloud_in_cell_deposit
// Cloud-in-cell mass deposit into a periodic 3D density grid.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries func, pos_x/y/z, mass_weight and
// cell_index. func = deposit spreads mass_weight over the eight cells around
// the particle with saturating adds; func = read returns one cell on the
// output channel (out_valid/out_ready, cell_value). Deposits give no result.
// A deposit sets up the axes in S_AXIS (one shared multiplier, one axis per
// cycle), then runs each corner through S_W1, S_W2, S_PROD and S_ADD (two
// weight products, mass product with the grid read, add and write back); the
// next transfer is taken only after the last corner. A read passes the RAM
// read register, then the output register; no transfer is taken meanwhile.
// The grid is a single RAM; each corner is read, updated and written before
// the next corner starts, so no two accesses overlap.
// After reset the grid is cleared one cell per cycle, all GRID_X*GRID_Y*GRID_Z
// cells (262144 by default), while in_ready stays low; config writes are
// taken as always. A stalled result stays in the output register and a new
// transfer is taken as soon as it leaves.
// ----------------------------------------------------------------------------
module cloud_in_cell_deposit
    import cic_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_index,
    input  logic [31:0]              cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     func,
    input  logic signed [31:0]       pos_x,
    input  logic signed [31:0]       pos_y,
    input  logic signed [31:0]       pos_z,
    input  logic signed [31:0]       mass_weight,
    input  logic [17:0]              cell_index,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [CELL_W-1:0] cell_value
);

    logic signed [31:0] org_reg [3];
    logic [31:0]        inv_reg [3];

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [1:0]        axis_reg, axis_next;
    logic [2:0]        corner_reg, corner_next;
    logic              out_valid_reg, out_valid_next;
    logic signed [CELL_W-1:0] cell_value_reg, cell_value_next;

    logic signed [31:0] pos_reg [3];
    logic signed [31:0] mass_reg;
    logic [AXB-1:0]     c_reg [3][2];
    logic [16:0]        h_reg [3][2];
    logic [16:0]        w1_reg, w2_reg;
    logic signed [49:0] prod_reg;

    logic               ram_we, ram_re;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [CELL_W-1:0]  ram_wdata, ram_rdata;

    logic signed [32:0] diff;
    logic signed [65:0] tprod;
    logic [15:0]        frac;
    logic [15:0]        absd;
    logic [AXB-1:0]     cbase;
    logic [AXB-1:0]     cnbr;
    logic [33:0]        m1, m2;
    logic signed [33:0] q;
    logic signed [CELL_W:0] sum;
    logic [ADDR_W-1:0]  corner_addr;
    logic               take;

    cic_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            inv_reg[0] <= INV_RESET;
            inv_reg[1] <= INV_RESET;
            inv_reg[2] <= INV_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X: org_reg[0] <= cfg_wdata;
                REG_ORIGIN_Y: org_reg[1] <= cfg_wdata;
                REG_ORIGIN_Z: org_reg[2] <= cfg_wdata;
                REG_INV_X:    inv_reg[0] <= cfg_wdata;
                REG_INV_Y:    inv_reg[1] <= cfg_wdata;
                REG_INV_Z:    inv_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // axis geometry, one axis per cycle
    always_comb
    begin
        diff  = {pos_reg[axis_reg][31], pos_reg[axis_reg]}
              - {org_reg[axis_reg][31], org_reg[axis_reg]};
        tprod = diff * $signed({1'b0, inv_reg[axis_reg]});
        frac  = tprod[39:24];
        cbase = tprod[40 +: AXB];
        absd  = frac[15] ? {1'b0, frac[14:0]} : (16'h8000 - frac);
        cnbr  = (frac > 16'h8000) ? (cbase + AXB'(1)) : (cbase - AXB'(1));
    end

    always_comb
    begin
        m1 = {17'd0, h_reg[0][corner_reg[0]]} * {17'd0, h_reg[1][corner_reg[1]]} + 34'd32768;
        m2 = {17'd0, w1_reg} * {17'd0, h_reg[2][corner_reg[2]]} + 34'd32768;
        q  = 34'((prod_reg + 50'sd32768) >>> 16);
        sum = {ram_rdata[CELL_W-1], ram_rdata} + (CELL_W+1)'(q);
        corner_addr = {c_reg[2][corner_reg[2]][ZB-1:0],
                       c_reg[1][corner_reg[1]][YB-1:0],
                       c_reg[0][corner_reg[0]][XB-1:0]};
    end

    assign take = in_valid && in_ready;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        axis_next       = axis_reg;
        corner_next     = corner_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        cell_value_next = cell_value_reg;
        in_ready        = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = corner_addr;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = corner_addr;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = !out_valid_reg || out_ready;
                if (take)
                begin
                    if (func == FUNC_READ)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = ADDR_W'(cell_index);
                        state_next = S_RDWAIT;
                    end
                    else
                    begin
                        axis_next  = '0;
                        state_next = S_AXIS;
                    end
                end
            end
            S_RDWAIT:
            begin
                out_valid_next  = 1'b1;
                cell_value_next = ram_rdata;
                state_next      = S_IDLE;
            end
            S_AXIS:
            begin
                axis_next = axis_reg + 2'd1;
                if (axis_reg == 2'd2)
                begin
                    corner_next = '0;
                    state_next  = S_W1;
                end
            end
            S_W1:
            begin
                state_next = S_W2;
            end
            S_W2:
            begin
                state_next = S_PROD;
            end
            S_PROD:
            begin
                ram_re     = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                ram_we = 1'b1;
                if (sum > $signed({2'b00, {(CELL_W-1){1'b1}}}))
                begin
                    ram_wdata = {1'b0, {(CELL_W-1){1'b1}}};
                end
                else if (sum < $signed({2'b11, {(CELL_W-1){1'b0}}}))
                begin
                    ram_wdata = {1'b1, {(CELL_W-1){1'b0}}};
                end
                else
                begin
                    ram_wdata = sum[CELL_W-1:0];
                end
                corner_next = corner_reg + 3'd1;
                state_next  = (corner_reg == 3'd7) ? S_IDLE : S_W1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            axis_reg      <= '0;
            corner_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            axis_reg      <= axis_next;
            corner_reg    <= corner_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_value_reg <= cell_value_next;
        if (take)
        begin
            pos_reg[0] <= pos_x;
            pos_reg[1] <= pos_y;
            pos_reg[2] <= pos_z;
            mass_reg   <= mass_weight;
        end
        if (state_reg == S_AXIS)
        begin
            c_reg[axis_reg][0] <= cbase;
            c_reg[axis_reg][1] <= cnbr;
            h_reg[axis_reg][0] <= 17'h10000 - {1'b0, absd};
            h_reg[axis_reg][1] <= {1'b0, absd};
        end
        if (state_reg == S_W1)
        begin
            w1_reg <= m1[32:16];
        end
        if (state_reg == S_W2)
        begin
            w2_reg <= m2[32:16];
        end
        if (state_reg == S_PROD)
        begin
            prod_reg <= $signed({1'b0, w2_reg}) * mass_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cell_value = cell_value_reg;

endmodule

[bench/cic_checker.sv]
// ----------------------------------------------------------------------------
// cic_checker
// Watches the config port and both channels of the cloud-in-cell deposit
// block, keeps its own copy of the density grid, predicts each cell read and
// compares it with the returned cell value.
// ----------------------------------------------------------------------------
module cic_checker
    import cic_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [2:0]               cfg_index,
    input  logic [31:0]              cfg_wdata,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic                     func,
    input  logic signed [31:0]       pos_x,
    input  logic signed [31:0]       pos_y,
    input  logic signed [31:0]       pos_z,
    input  logic signed [31:0]       mass_weight,
    input  logic [17:0]              cell_index,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic signed [CELL_W-1:0] cell_value,
    output int                       fail_count,
    output int                       pending
);

    localparam logic signed [63:0] CELL_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] CELL_LO = -64'sh0000_8000_0000_0000;

    logic signed [31:0] org_x, org_y, org_z;
    logic [31:0]        inv_x, inv_y, inv_z;
    logic signed [CELL_W-1:0] density [CELLS];
    logic signed [CELL_W-1:0] read_values [$];

    assign pending = read_values.size();

    task automatic axis_split(input logic signed [31:0] p, input logic signed [31:0] o,
                              input logic [31:0] inv, input int bits,
                              output int base, output int nbr,
                              output logic [16:0] h0, output logic [16:0] h1);
        logic signed [63:0] diff;
        logic [63:0] scaled;
        logic signed [17:0] d;
        int m;
        diff = 64'(p) - 64'(o);
        scaled = diff * {32'd0, inv};
        m = (1 << bits) - 1;
        base = int'(scaled[63:40]) & m;
        d = $signed({2'b00, scaled[39:24]}) - 18'sd32768;
        if (d < 0)
            d = -d;
        nbr = (scaled[39:24] > 16'd32768) ? ((base + 1) & m) : ((base + m) & m);
        h0 = 17'd65536 - 17'(d);
        h1 = 17'(d);
    endtask

    function automatic logic [63:0] mul_q16(input logic [63:0] a, input logic [63:0] b);
        return (a * b + 64'd32768) >> 16;
    endfunction

    function automatic logic signed [63:0] round_mass(input logic signed [63:0] p);
        logic signed [63:0] q;
        q = p + 64'sd32768;
        if (q >= 0)
            return q >>> 16;
        return -$signed(64'((64'(-q) + 64'd65535) >> 16));
    endfunction

    task automatic deposit_particle();
        int bx[2], by[2], bz[2];
        logic [16:0] wx[2], wy[2], wz[2];
        logic [63:0] w;
        logic signed [63:0] s;
        int idx;
        axis_split(pos_x, org_x, inv_x, XB, bx[0], bx[1], wx[0], wx[1]);
        axis_split(pos_y, org_y, inv_y, YB, by[0], by[1], wy[0], wy[1]);
        axis_split(pos_z, org_z, inv_z, ZB, bz[0], bz[1], wz[0], wz[1]);
        for (int k = 0; k < 2; k++)
            for (int j = 0; j < 2; j++)
                for (int i = 0; i < 2; i++)
                begin
                    w = mul_q16(mul_q16(64'(wx[i]), 64'(wy[j])), 64'(wz[k]));
                    idx = bx[i] + GRID_X * by[j] + GRID_X * GRID_Y * bz[k];
                    s = 64'(density[idx]) + round_mass($signed(w) * 64'(mass_weight));
                    if (s > CELL_HI)
                        s = CELL_HI;
                    if (s < CELL_LO)
                        s = CELL_LO;
                    density[idx] = s[CELL_W-1:0];
                end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x <= '0;
            org_y <= '0;
            org_z <= '0;
            inv_x <= INV_RESET;
            inv_y <= INV_RESET;
            inv_z <= INV_RESET;
            fail_count <= 0;
            read_values.delete();
            for (int n = 0; n < CELLS; n++)
                density[n] = '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ORIGIN_X: org_x <= cfg_wdata;
                    REG_ORIGIN_Y: org_y <= cfg_wdata;
                    REG_ORIGIN_Z: org_z <= cfg_wdata;
                    REG_INV_X:    inv_x <= cfg_wdata;
                    REG_INV_Y:    inv_y <= cfg_wdata;
                    REG_INV_Z:    inv_z <= cfg_wdata;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                if (func == FUNC_READ)
                    read_values.push_back(density[cell_index[ADDR_W-1:0]]);
                else
                    deposit_particle();
            end
            if (out_valid && out_ready)
            begin
                if (read_values.size() == 0)
                begin
                    $display("%0t: unexpected cell_value %0d", $time, cell_value);
                    fail_count <= fail_count + 1;
                end
                else if (read_values[0] !== cell_value)
                begin
                    $display("%0t: cell_value expected %0d actual %0d",
                             $time, read_values[0], cell_value);
                    fail_count <= fail_count + 1;
                    void'(read_values.pop_front());
                end
                else
                    void'(read_values.pop_front());
            end
        end
    end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the cloud-in-cell deposit block: config phases with extreme
// and random origins and cell sizes, deposits clustered in a few cells with
// read-back of those cells, random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top
    import cic_pkg::*;
();

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic func = FUNC_DEPOSIT;
    logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0, mass_weight = '0;
    logic [17:0] cell_index = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [CELL_W-1:0] cell_value;
    int fail_count, pending;
    int stall_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    cloud_in_cell_deposit u_dut (.*);

    cic_checker u_chk (.*);

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic send(input logic f, input logic [31:0] x, input logic [31:0] y,
                        input logic [31:0] z, input logic [31:0] m, input logic [17:0] c);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        mass_weight <= m;
        cell_index <= c;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic deposit_near(input logic [31:0] m);
        logic [31:0] x, y, z;
        x = {$urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3)), 16'($urandom)};
        y = {$urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3)), 16'($urandom)};
        z = {$urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 3)), 16'($urandom)};
        send(FUNC_DEPOSIT, x, y, z, m, 18'($urandom));
    endtask

    task automatic read_cell();
        logic [17:0] c;
        if ($urandom_range(0, 4) == 0)
            c = 18'($urandom);
        else
            c = 18'($urandom_range(0, 4))
                + 18'($urandom_range(0, 4)) * 18'(GRID_X)
                + 18'($urandom_range(0, 4)) * 18'(GRID_X * GRID_Y);
        send(FUNC_READ, $urandom, $urandom, $urandom, $urandom, c);
    endtask

    task automatic random_phase(input int count);
        logic [31:0] m;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 2) == 0)
                read_cell();
            else
            begin
                case ($urandom_range(0, 3))
                    0: m = $urandom;
                    1: m = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    default: m = 32'($signed($urandom_range(0, 400000)) - 200000);
                endcase
                deposit_near(m);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left <= gap_len();
        end
    end

    initial
    begin
        #200_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send(FUNC_READ, 0, 0, 0, 0, 18'h3FFFF);
        send(FUNC_DEPOSIT, 32'h0000_8000, 32'h0000_8000, 32'h0000_8000, 32'h0001_0000, 18'd0);
        send(FUNC_DEPOSIT, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 18'd0);
        send(FUNC_DEPOSIT, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 18'd0);
        send(FUNC_DEPOSIT, 32'h003F_C000, 32'h003F_4000, 32'h0000_4000, 32'h0001_8000, 18'd0);
        send(FUNC_DEPOSIT, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_8001, 32'hFFFF_FFFF, 18'd0);
        for (int n = 0; n < 8; n++)
            send(FUNC_DEPOSIT, 0, 0, 0, 32'h7FFF_FFFF, 18'd0);
        send(FUNC_READ, 0, 0, 0, 0, 18'd0);
        send(FUNC_READ, 0, 0, 0, 0, 18'd63);
        send(FUNC_READ, 0, 0, 0, 0, 18'h3FFFF);
        send(FUNC_READ, 0, 0, 0, 0, 18'd4095);
        send(FUNC_READ, 0, 0, 0, 0, 18'd1);
        drain();
        for (int n = 0; n < 8; n++)
            send(FUNC_DEPOSIT, 0, 0, 0, 32'h8000_0000, 18'd0);
        send(FUNC_READ, 0, 0, 0, 0, 18'd0);
        random_phase(200);
        drain();
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_ORIGIN_X, 32'h8000_0000);
                    write_reg(REG_ORIGIN_Y, 32'h7FFF_FFFF);
                    write_reg(REG_ORIGIN_Z, 32'h0001_8000);
                    write_reg(REG_INV_X, 32'hFFFF_FFFF);
                    write_reg(REG_INV_Y, 32'h0000_0001);
                    write_reg(REG_INV_Z, 32'h0000_0000);
                end
                1:
                begin
                    write_reg(REG_ORIGIN_X, $urandom);
                    write_reg(REG_ORIGIN_Y, $urandom);
                    write_reg(REG_ORIGIN_Z, $urandom);
                    write_reg(REG_INV_X, $urandom);
                    write_reg(REG_INV_Y, $urandom);
                    write_reg(REG_INV_Z, $urandom);
                end
                2:
                begin
                    write_reg(REG_ORIGIN_X, 32'h0000_0000);
                    write_reg(REG_ORIGIN_Y, 32'hFFFF_0000);
                    write_reg(REG_ORIGIN_Z, 32'h0000_0000);
                    write_reg(REG_INV_X, 32'h0200_0000);
                    write_reg(REG_INV_Y, 32'h0080_0000);
                    write_reg(REG_INV_Z, 32'h0155_5555);
                end
                default:
                begin
                    write_reg(REG_ORIGIN_X, 32'h0000_0000);
                    write_reg(REG_ORIGIN_Y, 32'h0000_0000);
                    write_reg(REG_ORIGIN_Z, 32'h0000_0000);
                    write_reg(REG_INV_X, INV_RESET);
                    write_reg(REG_INV_Y, INV_RESET);
                    write_reg(REG_INV_Z, INV_RESET);
                end
            endcase
            cfg_we <= 1'b0;
            random_phase(220);
            drain();
        end
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
